/* src/smsd_pkg.sv */
// ----------------------------------------------------------------------------
// Seed deriver package
// Shared types, register indexes and splitmix64 constants of the seed deriver.
// ----------------------------------------------------------------------------
`default_nettype none

package smsd_pkg;

	localparam logic [63:0] SM_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] SM_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] SM_MUL_B  = 64'h94d0_49bb_1331_11eb;
	localparam logic [63:0] CHILD_TAG = 64'h6368_696c_645f_5f5f;

	typedef enum logic [1:0] {
		MODE_CONTEXT = 2'd0,
		MODE_NEXT    = 2'd1,
		MODE_CHILD   = 2'd2,
		MODE_ROOT    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_BASE_SEED    = 2'd0,
		REG_DET_ON       = 2'd1,
		REG_CONTEXT_ON   = 2'd2,
		REG_CONTEXT_SEED = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE_A,
		ST_WAIT_A,
		ST_WAIT_B
	} state_t;

	typedef struct packed {
		mode_t       mode;
		logic [63:0] key_stream;
		logic [63:0] key_id;
		logic [31:0] par_seed;
	} in_t;

	typedef struct packed {
		logic [30:0] seed_out;
		logic        seed_valid;
	} out_t;

	typedef struct packed {
		logic [31:0] base_seed;
		logic        det_on;
		logic        context_on;
		logic [31:0] context_seed;
		logic [63:0] task_count;
		logic [63:0] child_count;
	} cfg_t;

	typedef struct packed {
		logic task_inc;
		logic child_inc;
	} cnt_inc_t;

endpackage

`default_nettype wire

/* src/smsd_cfg.sv */
// ----------------------------------------------------------------------------
// Seed deriver configuration registers
// APB register file with the task and child counters of the next-call mode.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_cfg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [3:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  wire smsd_pkg::cnt_inc_t cnt_inc,
	output smsd_pkg::cfg_t        cfg
);

	logic [31:0] base_seed_q;
	logic        det_on_q;
	logic        context_on_q;
	logic [31:0] context_seed_q;
	logic [63:0] task_count_q;
	logic [63:0] child_count_q;
	logic        wr_en;
	smsd_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = smsd_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seed_q    <= 32'd1;
			det_on_q       <= 1'b0;
			context_on_q   <= 1'b0;
			context_seed_q <= 32'd0;
			task_count_q   <= 64'd0;
			child_count_q  <= 64'd0;
		end else begin
			if (cnt_inc.task_inc) begin
				task_count_q <= task_count_q + 64'd1;
			end
			if (cnt_inc.child_inc) begin
				child_count_q <= child_count_q + 64'd1;
			end
			if (wr_en) begin
				unique case (idx)
					smsd_pkg::REG_BASE_SEED: begin
						// A zero base seed is stored as one.
						base_seed_q  <= (pwdata == 32'd0) ? 32'd1 : pwdata;
						task_count_q <= 64'd0;
					end
					smsd_pkg::REG_DET_ON: begin
						det_on_q <= pwdata[0];
					end
					smsd_pkg::REG_CONTEXT_ON: begin
						context_on_q <= pwdata[0];
					end
					smsd_pkg::REG_CONTEXT_SEED: begin
						context_seed_q <= pwdata;
						child_count_q  <= 64'd0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		unique case (idx)
			smsd_pkg::REG_BASE_SEED:    prdata = base_seed_q;
			smsd_pkg::REG_DET_ON:       prdata = {31'd0, det_on_q};
			smsd_pkg::REG_CONTEXT_ON:   prdata = {31'd0, context_on_q};
			smsd_pkg::REG_CONTEXT_SEED: prdata = context_seed_q;
			default:                    prdata = 32'd0;
		endcase
	end

	assign cfg.base_seed    = base_seed_q;
	assign cfg.det_on       = det_on_q;
	assign cfg.context_on   = context_on_q;
	assign cfg.context_seed = context_seed_q;
	assign cfg.task_count   = task_count_q;
	assign cfg.child_count  = child_count_q;

endmodule

`default_nettype wire

/* src/smsd_mul64.sv */
// ----------------------------------------------------------------------------
// Seed deriver multiplier
// Iterative 64x64 multiply keeping the low 64 bits, one 32x32 partial a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_mul64 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] op_a,
	input  wire logic [63:0] op_b,
	output logic             done,
	output logic [63:0]      product
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [63:0] prod_s1;
	logic [1:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] mul_p;

	// Step 0: lo*lo, step 1: lo(a)*hi(b), step 2: hi(a)*lo(b). The cross
	// terms only reach the upper half of the result.
	always_comb begin
		mul_x = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		mul_y = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
		mul_p = {32'd0, mul_x} * {32'd0, mul_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= 2'd0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
		end else if (run_q) begin
			prod_s1 <= mul_p;
			unique case (step_q)
				2'd0: begin
				end
				2'd1: acc_q <= prod_s1;
				2'd2: acc_q[63:32] <= acc_q[63:32] + prod_s1[31:0];
				2'd3: acc_q[63:32] <= acc_q[63:32] + prod_s1[31:0];
				default: begin
				end
			endcase
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

/* src/splitmix_seed_deriver_unit.sv */
// ----------------------------------------------------------------------------
// Splitmix seed deriver
// Derives a nonzero 31-bit seed from a base, context or parent seed and two
// 64-bit keys via two splitmix64 finalizer rounds on one shared multiplier.
// ----------------------------------------------------------------------------
// A derived seed strobes after the four dependent 64-bit multiplies of its
// two rounds have run in turn on the shared 32x32 multiplier; busy drops in
// that same cycle, so a new command can be taken then, but never while busy.
// A context command with deterministic mode off strobes its invalid result
// in the cycle after acceptance without raising busy. Reset restores the
// register defaults and clears both counters; results cannot be stalled by
// the receiver.
`default_nettype none

module splitmix_seed_deriver_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire smsd_pkg::in_t cmd,
	output logic               strobe,
	output smsd_pkg::out_t     result,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	smsd_pkg::state_t   state_q;
	smsd_pkg::state_t   state_d;
	smsd_pkg::cfg_t     cfg;
	smsd_pkg::cnt_inc_t cnt_inc;

	logic        accept;
	logic        cmd_ok;
	logic [63:0] sel_start;
	logic [63:0] sel_stream;
	logic [63:0] sel_id;
	logic [63:0] v_q;
	logic [63:0] id_q;
	logic        round_q;
	logic        strobe_q;
	logic [30:0] seed_q;
	logic        valid_q;
	logic        mul_start;
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic        mul_done;
	logic [63:0] mul_res;
	logic [63:0] fin;
	logic [30:0] fin_seed;

	// Golden-ratio add followed by the first xor-shift of a round.
	function automatic logic [63:0] pre_mix(input logic [63:0] x);
		logic [63:0] y;
		y = x + smsd_pkg::SM_GOLDEN;
		return y ^ (y >> 30);
	endfunction

	smsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cnt_inc (cnt_inc),
		.cfg     (cfg)
	);

	smsd_mul64 u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.done    (mul_done),
		.product (mul_res)
	);

	assign busy   = (state_q != smsd_pkg::ST_IDLE);
	assign accept = start && !busy;

	// Operand selection per mode.
	always_comb begin
		sel_start = {32'd0, cfg.base_seed};
		sel_stream = cmd.key_stream;
		sel_id    = cmd.key_id;
		cmd_ok    = 1'b1;
		cnt_inc   = '0;
		unique case (cmd.mode)
			smsd_pkg::MODE_CONTEXT: begin
				cmd_ok = cfg.det_on;
				if (cfg.context_on) begin
					sel_start = {32'd0, cfg.context_seed} ^ smsd_pkg::CHILD_TAG;
				end
			end
			smsd_pkg::MODE_NEXT: begin
				cmd_ok = cfg.det_on;
				if (cfg.context_on) begin
					sel_start = {32'd0, cfg.context_seed} ^ smsd_pkg::CHILD_TAG;
					sel_id    = cfg.child_count;
					cnt_inc.child_inc = accept && cfg.det_on;
				end else begin
					sel_stream = cmd.key_stream ^ smsd_pkg::CHILD_TAG;
					sel_id     = cfg.task_count;
					cnt_inc.task_inc = accept && cfg.det_on;
				end
			end
			smsd_pkg::MODE_CHILD: begin
				sel_start = {32'd0, cmd.par_seed} ^ smsd_pkg::CHILD_TAG;
			end
			smsd_pkg::MODE_ROOT: begin
			end
			default: begin
			end
		endcase
	end

	assign fin      = mul_res ^ (mul_res >> 31);
	assign fin_seed = (fin[30:0] == 31'd0) ? 31'd1 : fin[30:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smsd_pkg::ST_IDLE: begin
				if (accept && cmd_ok) begin
					state_d = smsd_pkg::ST_ISSUE_A;
				end
			end
			smsd_pkg::ST_ISSUE_A: state_d = smsd_pkg::ST_WAIT_A;
			smsd_pkg::ST_WAIT_A: begin
				if (mul_done) begin
					state_d = smsd_pkg::ST_WAIT_B;
				end
			end
			smsd_pkg::ST_WAIT_B: begin
				if (mul_done) begin
					state_d = round_q ? smsd_pkg::ST_IDLE : smsd_pkg::ST_ISSUE_A;
				end
			end
			default: state_d = smsd_pkg::ST_IDLE;
		endcase
	end

	// Multiplier control.
	always_comb begin
		mul_start = 1'b0;
		mul_a     = v_q;
		mul_b     = smsd_pkg::SM_MUL_A;
		unique case (state_q)
			smsd_pkg::ST_ISSUE_A: begin
				mul_start = 1'b1;
			end
			smsd_pkg::ST_WAIT_A: begin
				mul_start = mul_done;
				mul_a     = mul_res ^ (mul_res >> 27);
				mul_b     = smsd_pkg::SM_MUL_B;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= smsd_pkg::ST_IDLE;
			round_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (accept) begin
				round_q  <= 1'b0;
				strobe_q <= !cmd_ok;
			end else if (state_q == smsd_pkg::ST_WAIT_B && mul_done) begin
				round_q  <= 1'b1;
				strobe_q <= round_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q     <= pre_mix(sel_start ^ sel_stream);
			id_q    <= sel_id;
			seed_q  <= 31'd0;
			valid_q <= 1'b0;
		end else if (state_q == smsd_pkg::ST_WAIT_B && mul_done) begin
			v_q     <= pre_mix(fin ^ id_q);
			seed_q  <= fin_seed;
			valid_q <= 1'b1;
		end
	end

	assign strobe            = strobe_q;
	assign result.seed_out   = seed_q;
	assign result.seed_valid = valid_q;

	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.seed_valid |-> result.seed_out != 31'd0)
		else $error("valid seed is zero");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.seed_valid |-> result.seed_out == 31'd0)
		else $error("invalid result carries a seed");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == smsd_pkg::ST_WAIT_A || state_q == smsd_pkg::ST_WAIT_B)
		else $error("multiplier finished outside a wait state");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	a_strobe_cause: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start) || $past(busy))
		else $error("result beat without a command");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed deriver testbench
// Drives a directed table and then randomized command phases into the seed
// deriver, predicts every derived seed with its own splitmix64 model, and
// compares each strobed result against the oldest pending expectation.
// ----------------------------------------------------------------------------

module tb;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_ITEMS   = 150;
	localparam int DRAIN_CYCLES  = 40;
	localparam smsd_pkg::out_t NO_SEED = '{seed_out: 31'd0, seed_valid: 1'b0};

	typedef struct {
		bit                 is_cfg;
		smsd_pkg::reg_idx_t idx;
		logic [31:0]        val;
		smsd_pkg::in_t      c;
		bit                 typed;
		smsd_pkg::out_t     want;
	} plan_row_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	smsd_pkg::in_t  cmd;
	logic           strobe;
	smsd_pkg::out_t result;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [3:0]     paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	smsd_pkg::cfg_t model;
	smsd_pkg::out_t seed_q[$];
	plan_row_t      plan_q[$];
	int             errors;
	int             cycles = 0;
	int             burst_left;

	splitmix_seed_deriver_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.strobe  (strobe),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One splitmix64 finalizer round.
	function automatic logic [63:0] mix64(logic [63:0] v);
		logic [63:0] x;
		x = v + smsd_pkg::SM_GOLDEN;
		x = (x ^ (x >> 30)) * smsd_pkg::SM_MUL_A;
		x = (x ^ (x >> 27)) * smsd_pkg::SM_MUL_B;
		return x ^ (x >> 31);
	endfunction

	function automatic logic [30:0] seed_from(logic [63:0] origin, logic [63:0] stream,
			logic [63:0] id);
		logic [63:0] v;
		v = mix64(origin ^ stream);
		v = mix64(v ^ id);
		return (v[30:0] == 31'd0) ? 31'd1 : v[30:0];
	endfunction

	// Expected result of one command; advances the call counters as the block does.
	function automatic smsd_pkg::out_t derive_seed(smsd_pkg::in_t c);
		logic [63:0]    ctx_origin;
		smsd_pkg::out_t r;
		ctx_origin = {32'd0, model.context_seed} ^ smsd_pkg::CHILD_TAG;
		r = '{seed_out: 31'd0, seed_valid: 1'b1};
		case (c.mode)
			smsd_pkg::MODE_CONTEXT: begin
				if (!model.det_on)
					r = NO_SEED;
				else if (model.context_on)
					r.seed_out = seed_from(ctx_origin, c.key_stream, c.key_id);
				else
					r.seed_out = seed_from({32'd0, model.base_seed}, c.key_stream, c.key_id);
			end
			smsd_pkg::MODE_NEXT: begin
				if (!model.det_on) begin
					r = NO_SEED;
				end else if (model.context_on) begin
					r.seed_out = seed_from(ctx_origin, c.key_stream, model.child_count);
					model.child_count = model.child_count + 64'd1;
				end else begin
					r.seed_out = seed_from({32'd0, model.base_seed},
						smsd_pkg::CHILD_TAG ^ c.key_stream, model.task_count);
					model.task_count = model.task_count + 64'd1;
				end
			end
			smsd_pkg::MODE_CHILD: begin
				r.seed_out = seed_from({32'd0, c.par_seed} ^ smsd_pkg::CHILD_TAG,
					c.key_stream, c.key_id);
			end
			default: begin
				r.seed_out = seed_from({32'd0, model.base_seed}, c.key_stream, c.key_id);
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] pick64();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return {64{1'b1}};
			2: return 64'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic add_cmd(smsd_pkg::mode_t m, logic [63:0] st, logic [63:0] id,
			logic [31:0] par, bit typed);
		plan_row_t row;
		row = '{is_cfg: 1'b0, idx: smsd_pkg::REG_BASE_SEED, val: 32'd0,
			c: '{mode: m, key_stream: st, key_id: id, par_seed: par},
			typed: typed, want: NO_SEED};
		plan_q.push_back(row);
	endtask

	task automatic add_cfg(smsd_pkg::reg_idx_t idx, logic [31:0] val);
		plan_row_t row;
		row = '{is_cfg: 1'b1, idx: idx, val: val, c: '0, typed: 1'b0, want: NO_SEED};
		plan_q.push_back(row);
	endtask

	// Registers are only written once the block is idle and nothing is pending.
	task automatic write_reg(smsd_pkg::reg_idx_t idx, logic [31:0] val);
		start <= 1'b0;
		while (seed_q.size() != 0 || busy)
			@(posedge clk);
		repeat (2) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			smsd_pkg::REG_BASE_SEED: begin
				model.base_seed  = (val == 32'd0) ? 32'd1 : val;
				model.task_count = 64'd0;
			end
			smsd_pkg::REG_DET_ON:     model.det_on = val[0];
			smsd_pkg::REG_CONTEXT_ON: model.context_on = val[0];
			default: begin
				model.context_seed = val;
				model.child_count  = 64'd0;
			end
		endcase
	endtask

	// Holds the command until the beat is taken, then records what it must yield.
	task automatic drive_cmd(smsd_pkg::in_t c, bit typed, smsd_pkg::out_t want);
		smsd_pkg::out_t pred;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = derive_seed(c);
		seed_q.push_back(typed ? want : pred);
	endtask

	// Sender pacing: bursts of back-to-back commands separated by random gaps.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 25);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (seed_q.size() == 0) begin
				$display("%0t: unexpected result, got seed %h valid %b", $time,
					result.seed_out, result.seed_valid);
				errors++;
			end else begin
				smsd_pkg::out_t want;
				want = seed_q.pop_front();
				if (result.seed_out !== want.seed_out) begin
					$display("%0t: seed_out mismatch, expected %h, got %h", $time,
						want.seed_out, result.seed_out);
					errors++;
				end
				if (result.seed_valid !== want.seed_valid) begin
					$display("%0t: seed_valid mismatch, expected %b, got %b", $time,
						want.seed_valid, result.seed_valid);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		smsd_pkg::in_t c;
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		errors     = 0;
		burst_left = 0;
		model      = '0;
		model.base_seed = 32'd1;

		// Reset state: deterministic mode is off, so context modes yield no seed.
		add_cmd(smsd_pkg::MODE_CONTEXT, 64'd0, 64'd0, 32'd0, 1'b1);
		add_cmd(smsd_pkg::MODE_NEXT, {64{1'b1}}, {64{1'b1}}, 32'hffff_ffff, 1'b1);
		add_cmd(smsd_pkg::MODE_CHILD, 64'd0, 64'd0, 32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_CHILD, {64{1'b1}}, {64{1'b1}}, 32'hffff_ffff, 1'b0);
		add_cmd(smsd_pkg::MODE_ROOT, 64'd0, 64'd0, 32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_ROOT, {64{1'b1}}, {64{1'b1}}, 32'd0, 1'b0);
		// Root path of the context modes, with the task counter running.
		add_cfg(smsd_pkg::REG_DET_ON, 32'd1);
		add_cmd(smsd_pkg::MODE_NEXT, 64'd0, 64'd0, 32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_NEXT, {64{1'b1}}, 64'd0, 32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_CONTEXT, {64{1'b1}}, 64'd0, 32'd0, 1'b0);
		// A zero base seed is stored as one and the task counter restarts.
		add_cfg(smsd_pkg::REG_BASE_SEED, 32'd0);
		add_cmd(smsd_pkg::MODE_NEXT, 64'd0, 64'd0, 32'd0, 1'b0);
		add_cfg(smsd_pkg::REG_BASE_SEED, 32'hffff_ffff);
		add_cmd(smsd_pkg::MODE_ROOT, 64'd0, {64{1'b1}}, 32'd0, 1'b0);
		// Child path with the per-context counter.
		add_cfg(smsd_pkg::REG_CONTEXT_SEED, 32'hffff_ffff);
		add_cfg(smsd_pkg::REG_CONTEXT_ON, 32'd1);
		add_cmd(smsd_pkg::MODE_CONTEXT, 64'd0, 64'd0, 32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_NEXT, 64'h5a5a_a5a5_0f0f_f0f0, 64'd0, 32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_NEXT, 64'h5a5a_a5a5_0f0f_f0f0, 64'd0, 32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_NEXT, 64'h5a5a_a5a5_0f0f_f0f0, 64'd0, 32'd0, 1'b0);
		add_cfg(smsd_pkg::REG_CONTEXT_SEED, 32'd0);
		add_cmd(smsd_pkg::MODE_NEXT, 64'h5a5a_a5a5_0f0f_f0f0, 64'd0, 32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_CONTEXT, {64{1'b1}}, {64{1'b1}}, 32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_ROOT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
			32'd0, 1'b0);
		add_cmd(smsd_pkg::MODE_CHILD, 64'd1, 64'd1, 32'd0, 1'b0);
		// With deterministic mode off again the counters must hold.
		add_cfg(smsd_pkg::REG_DET_ON, 32'd0);
		add_cmd(smsd_pkg::MODE_CONTEXT, 64'd7, 64'd7, 32'd0, 1'b1);
		add_cmd(smsd_pkg::MODE_NEXT, 64'd7, 64'd7, 32'd0, 1'b1);
		add_cfg(smsd_pkg::REG_DET_ON, 32'd1);
		add_cmd(smsd_pkg::MODE_NEXT, 64'h5a5a_a5a5_0f0f_f0f0, 64'd0, 32'd0, 1'b0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan_q[i]) begin
			if (plan_q[i].is_cfg) begin
				write_reg(plan_q[i].idx, plan_q[i].val);
			end else begin
				drive_cmd(plan_q[i].c, plan_q[i].typed, plan_q[i].want);
				pace();
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			// Some registers keep their value so counters run on across phases.
			if (ph == 0 || $urandom_range(0, 1))
				write_reg(smsd_pkg::REG_BASE_SEED, pick32());
			if (ph == 0 || $urandom_range(0, 3) != 0)
				write_reg(smsd_pkg::REG_DET_ON,
					($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
			if (ph == 0 || $urandom_range(0, 1))
				write_reg(smsd_pkg::REG_CONTEXT_ON, 32'($urandom_range(0, 1)));
			if (ph == 0 || $urandom_range(0, 1))
				write_reg(smsd_pkg::REG_CONTEXT_SEED, pick32());
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				c.mode       = smsd_pkg::mode_t'($urandom_range(0, 3));
				c.key_stream = pick64();
				c.key_id     = pick64();
				c.par_seed   = pick32();
				drive_cmd(c, 1'b0, NO_SEED);
				pace();
			end
		end

		start <= 1'b0;
		while (seed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
